FILE: design/rbf_pkg.sv
// shared types, codes and the backoff delay table for the reconnect state machine
// no dependencies; used by rbf_step and reconnect_backoff_fsm_unit
package rbf_pkg;

    localparam int TIME_W    = 32;
    localparam int ATT_W     = 8;
    localparam int DELAY_W   = 12;
    localparam int FUNC_W    = 2;
    localparam int ACTION_W  = 2;
    localparam int STATE_W   = 2;

    localparam int BACKOFF_STEPS = 6;
    localparam int TABLE_LEN     = 6;

    localparam logic [ATT_W-1:0] ATTEMPT_MAX = 8'hFF;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CONNECT    = 2'd0,
        FUNC_DISCONNECT = 2'd1,
        FUNC_TICK       = 2'd2,
        FUNC_UNKNOWN    = 2'd3
    } func_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_NONE      = 2'd0,
        ACT_WAIT      = 2'd1,
        ACT_START_ADV = 2'd2
    } action_t;

    typedef enum logic [STATE_W-1:0] {
        ST_DISCONNECTED = 2'd0,
        ST_ADVERTISING  = 2'd1,
        ST_BACKOFF      = 2'd2,
        ST_CONNECTED    = 2'd3
    } link_state_t;

    typedef struct packed {
        link_state_t         link;
        logic [ATT_W-1:0]    attempts;
        logic [DELAY_W-1:0]  backoff;
        logic [TIME_W-1:0]   wake;
    } link_ctx_t;

    // delay for an attempt count, index clamped to the last configured step
    function automatic logic [DELAY_W-1:0] delay_lookup(input logic [ATT_W-1:0] att);
        logic [ATT_W-1:0]   idx;
        logic [DELAY_W-1:0] d;
        idx = (att == '0) ? '0 : att - 1'b1;
        if (idx > ATT_W'(BACKOFF_STEPS - 1))
        begin
            idx = ATT_W'(BACKOFF_STEPS - 1);
        end
        if (idx >= ATT_W'(TABLE_LEN))
        begin
            idx = ATT_W'(TABLE_LEN - 1);
        end
        case (idx)
            8'd0:    d = 12'd100;
            8'd1:    d = 12'd200;
            8'd2:    d = 12'd400;
            8'd3:    d = 12'd800;
            8'd4:    d = 12'd1600;
            default: d = 12'd3000;
        endcase
        return d;
    endfunction

endpackage

FILE: design/rbf_step.sv
// next-state and action logic for one link event
// depends on rbf_pkg
module rbf_step (
    input  logic [rbf_pkg::FUNC_W-1:0] func,
    input  logic [rbf_pkg::TIME_W-1:0] now_ms,
    input  rbf_pkg::link_ctx_t         cur,
    output rbf_pkg::link_ctx_t         nxt,
    output rbf_pkg::action_t           action
);
    import rbf_pkg::*;

    logic [ATT_W-1:0]   att_new;
    logic [DELAY_W-1:0] delay_new;

    always_comb
    begin
        if (cur.link == ST_CONNECTED)
        begin
            att_new = ATT_W'(1);
        end
        else if (cur.attempts < ATTEMPT_MAX)
        begin
            att_new = cur.attempts + 1'b1;
        end
        else
        begin
            att_new = cur.attempts;
        end
        delay_new = delay_lookup(att_new);
    end

    always_comb
    begin
        nxt    = cur;
        action = ACT_NONE;
        case (func_t'(func))
            FUNC_CONNECT:
            begin
                if (cur.link != ST_CONNECTED)
                begin
                    nxt.link     = ST_CONNECTED;
                    nxt.attempts = '0;
                    nxt.backoff  = '0;
                    nxt.wake     = '0;
                end
            end
            FUNC_DISCONNECT:
            begin
                if (cur.link != ST_DISCONNECTED)
                begin
                    nxt.link     = ST_BACKOFF;
                    nxt.attempts = att_new;
                    nxt.backoff  = delay_new;
                    // deadline wraps modulo 2^32
                    nxt.wake     = now_ms + TIME_W'(delay_new);
                    action       = ACT_WAIT;
                end
            end
            FUNC_TICK:
            begin
                if (cur.link == ST_BACKOFF)
                begin
                    if (now_ms < cur.wake)
                    begin
                        action = ACT_WAIT;
                    end
                    else
                    begin
                        nxt.link = ST_ADVERTISING;
                        action   = ACT_START_ADV;
                    end
                end
            end
            default:
            begin
                action = ACT_NONE;
            end
        endcase
    end

endmodule

FILE: design/reconnect_backoff_fsm_unit.sv
// Link reconnect state machine with exponential backoff. Each event request
// is captured in an input register, evaluated combinationally against the
// held link state, and its result lands in an output register; while the
// output is not stalled a new request is taken every cycle, so throughput is
// one event per clock. The link context register updates as the request
// moves to the output register, so back-to-back events see each other's
// effect. Output stall holds both stages.
// depends on rbf_pkg and rbf_step
module reconnect_backoff_fsm_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          evt_valid,
    output logic                          evt_stall,
    input  logic [rbf_pkg::FUNC_W-1:0]    func,
    input  logic [rbf_pkg::TIME_W-1:0]    now_ms,
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic [rbf_pkg::ACTION_W-1:0]  action,
    output logic [rbf_pkg::STATE_W-1:0]   state_after,
    output logic [rbf_pkg::ATT_W-1:0]     attempt_after,
    output logic [rbf_pkg::DELAY_W-1:0]   delay_after,
    output logic [rbf_pkg::TIME_W-1:0]    deadline_after
);
    import rbf_pkg::*;

    logic                in_valid_reg;
    logic [FUNC_W-1:0]   func_reg;
    logic [TIME_W-1:0]   now_reg;
    link_ctx_t           ctx_reg;
    link_ctx_t           ctx_next;
    action_t             act_next;
    logic                out_valid_reg;
    action_t             act_reg;
    link_ctx_t           res_reg;
    logic                advance;

    // input register holds a request and output register is free, or emptying this cycle
    assign advance   = in_valid_reg && (!out_valid_reg || !res_stall);
    assign evt_stall = in_valid_reg && !advance;

    rbf_step u_step (
        .func   (func_reg),
        .now_ms (now_reg),
        .cur    (ctx_reg),
        .nxt    (ctx_next),
        .action (act_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ctx_reg       <= '{link: ST_DISCONNECTED, attempts: '0, backoff: '0, wake: '0};
        end
        else
        begin
            if (!evt_stall)
            begin
                in_valid_reg <= evt_valid;
            end
            if (advance)
            begin
                ctx_reg       <= ctx_next;
                out_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!evt_stall && evt_valid)
        begin
            func_reg <= func;
            now_reg  <= now_ms;
        end
        if (advance)
        begin
            act_reg <= act_next;
            res_reg <= ctx_next;
        end
    end

    assign res_valid      = out_valid_reg;
    assign action         = act_reg;
    assign state_after    = res_reg.link;
    assign attempt_after  = res_reg.attempts;
    assign delay_after    = res_reg.backoff;
    assign deadline_after = res_reg.wake;

`ifndef SYNTH
    a_adv_state: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && act_reg == ACT_START_ADV) |-> (res_reg.link == ST_ADVERTISING))
        else $error("start advertising without advertising state");

    a_wait_backoff: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && act_reg == ACT_WAIT) |-> (res_reg.link == ST_BACKOFF && res_reg.backoff != '0))
        else $error("wait reported outside backoff");

    a_connected_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_reg.link == ST_CONNECTED)
            |-> (res_reg.attempts == '0 && res_reg.backoff == '0 && res_reg.wake == '0))
        else $error("connected link with stale backoff context");

    a_ctx_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(ctx_reg))
        else $error("link context changed without a request");
`endif

endmodule
